/* src/bckt_pkg.sv */
// Shared types and constants for the bounded counted key table.
package bckt_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int KEY_PORT_BITS   = 16;
    localparam int COUNT_PORT_BITS = 16;
    localparam int CAP_BITS        = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DEL    = 2'd1,
        REQ_USE    = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_ROOM   = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

endpackage

/* src/bounded_counted_key_table.sv */
// Bounded counted key table: top level with request sequencer and entry RAM.
// The table holds up to min(capacity, ENTRIES) distinct keys with counts, packed
// in insertion order in one simple dual-port RAM (one read and one write a
// cycle); a fill count marks how many leading entries are live, so no reset
// sweep is needed. Requests are handled one at a time. A request is taken
// while the sequencer is idle, even if the previous response still waits in
// the output register. The key search reads one entry per cycle from the RAM
// and stops at the first hit or after the last live entry. Removing an entry
// (delete, or a use that drops the count to zero) then moves every later
// entry down by one, reading it in S_SH_RD and writing it in S_SH_WR. Adds
// saturate at the all-ones count. The capacity register may be written at
// any time the table is idle; lowering it below the current occupancy keeps
// existing entries and only refuses new keys.
module bounded_counted_key_table import bckt_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // capacity write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CAP_BITS-1:0]        i_cfg_capacity,
    // request channel
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [KEY_PORT_BITS-1:0]   i_item_key,
    // response channel
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output logic [1:0]                 o_status,
    output logic [COUNT_PORT_BITS-1:0] o_count_after,
    output logic                       o_entry_removed
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int LIM_W  = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;
    localparam int WORD_W = KEY_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // control state
    t_state               r_state, n_state;
    logic [CAP_BITS-1:0]  r_cap;
    logic [OCC_W-1:0]     r_occ, n_occ;
    logic [OCC_W-1:0]     r_idx, n_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    logic                 r_rsp_valid, n_rsp_valid;

    // per-request working registers
    t_req                 r_type, n_type;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    t_status              r_res_status, n_res_status;
    logic [COUNT_BITS-1:0] r_res_cnt, n_res_cnt;
    logic                 r_res_rm, n_res_rm;

    // output register
    logic [1:0]                 r_status, n_status;
    logic [COUNT_PORT_BITS-1:0] r_count, n_count;
    logic                       r_removed, n_removed;

    // RAM port
    logic              w_we, w_re;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    logic [WORD_W-1:0] w_wdata, w_rdata;

    logic [KEY_BITS-1:0]   w_rd_key;
    logic [COUNT_BITS-1:0] w_rd_cnt;
    logic [KEY_BITS-1:0]   w_req_key;
    logic [KEY_BITS+KEY_PORT_BITS-1:0]     w_key_ext;
    logic [COUNT_BITS+COUNT_PORT_BITS-1:0] w_cnt_ext;
    logic [COUNT_BITS-1:0] w_cnt_inc, w_cnt_dec;
    logic [OCC_W-1:0]      w_idx_nx;
    logic                  w_room, w_hit;

    bckt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // key compared in its low KEY_BITS bits, zero-extended when wider than the port
    assign w_key_ext = {{KEY_BITS{1'b0}}, i_item_key};
    assign w_req_key = w_key_ext[KEY_BITS-1:0];

    assign w_rd_key  = w_rdata[WORD_W-1:COUNT_BITS];
    assign w_rd_cnt  = w_rdata[COUNT_BITS-1:0];
    assign w_cnt_inc = r_cnt + CNT_ONE;
    assign w_cnt_dec = r_cnt - CNT_ONE;
    assign w_idx_nx  = r_idx + OCC_W'(1);
    assign w_hit     = r_cmp_vld && (w_rd_key == r_key);

    // room: occupancy below both the capacity register and the table size
    assign w_room = (LIM_W'(r_occ) < LIM_W'(r_cap)) && (r_occ < OCC_W'(ENTRIES));

    // response count: low 16 bits of the count
    assign w_cnt_ext = {{COUNT_PORT_BITS{1'b0}}, r_res_cnt};

    assign o_req_ready     = (r_state == S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_rsp_valid     = r_rsp_valid;
    assign o_status        = r_status;
    assign o_count_after   = r_count;
    assign o_entry_removed = r_removed;

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_type       = r_type;
        n_key        = r_key;
        n_found      = r_found;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_cnt    = r_res_cnt;
        n_res_rm     = r_res_rm;
        n_rsp_valid  = r_rsp_valid && !i_rsp_ready;
        n_status     = r_status;
        n_count      = r_count;
        n_removed    = r_removed;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_type    = t_req'(i_req_type);
                    n_key     = w_req_key;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end

            // one read issued per cycle; the compare checks the RAM's registered read data against the key
            S_SCAN: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    n_pos   = r_cmp_idx;
                    n_cnt   = w_rd_cnt;
                    n_state = S_ACT;
                end else if (r_idx == r_occ) begin
                    n_found = 1'b0;
                    n_state = S_ACT;
                end else begin
                    w_re      = 1'b1;
                    w_raddr   = r_idx[IDX_W-1:0];
                    n_cmp_idx = r_idx[IDX_W-1:0];
                    n_cmp_vld = 1'b1;
                    n_idx     = w_idx_nx;
                end
            end

            S_ACT: begin
                n_res_status = ST_OK;
                n_res_cnt    = '0;
                n_res_rm     = 1'b0;
                n_state      = S_DONE;
                unique case (r_type)
                    REQ_ADD: begin
                        if (r_found) begin
                            if (r_cnt == CNT_MAX) begin
                                n_res_status = ST_SATURATED;
                                n_res_cnt    = r_cnt;
                            end else begin
                                w_we      = 1'b1;
                                w_waddr   = r_pos;
                                w_wdata   = {r_key, w_cnt_inc};
                                n_res_cnt = w_cnt_inc;
                            end
                        end else if (w_room) begin
                            w_we      = 1'b1;
                            w_waddr   = r_occ[IDX_W-1:0];
                            w_wdata   = {r_key, CNT_ONE};
                            n_occ     = r_occ + OCC_W'(1);
                            n_res_cnt = CNT_ONE;
                        end else begin
                            n_res_status = ST_NO_ROOM;
                        end
                    end
                    REQ_DEL: begin
                        if (r_found) begin
                            n_res_rm = 1'b1;
                            n_idx    = OCC_W'(r_pos);
                            n_state  = S_SH_RD;
                        end else begin
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                    REQ_USE: begin
                        if (!r_found) begin
                            n_res_status = ST_NOT_FOUND;
                        end else if (r_cnt <= CNT_ONE) begin
                            n_res_rm = 1'b1;
                            n_idx    = OCC_W'(r_pos);
                            n_state  = S_SH_RD;
                        end else begin
                            w_we      = 1'b1;
                            w_waddr   = r_pos;
                            w_wdata   = {r_key, w_cnt_dec};
                            n_res_cnt = w_cnt_dec;
                        end
                    end
                    REQ_LOOKUP: begin
                        if (r_found) begin
                            n_res_cnt = r_cnt;
                        end else begin
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_res_status = ST_NOT_FOUND;
                    end
                endcase
            end

            // close the gap: move entry idx+1 down to idx until the last live one
            S_SH_RD: begin
                if ({1'b0, w_idx_nx} < {1'b0, r_occ}) begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_nx[IDX_W-1:0];
                    n_state = S_SH_WR;
                end else begin
                    n_occ   = r_occ - OCC_W'(1);
                    n_state = S_DONE;
                end
            end

            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IDX_W-1:0];
                w_wdata = w_rdata;
                n_idx   = w_idx_nx;
                n_state = S_SH_RD;
            end

            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid = 1'b1;
                    n_status    = r_res_status;
                    n_count     = w_cnt_ext[COUNT_PORT_BITS-1:0];
                    n_removed   = r_res_rm;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type       <= n_type;
        r_key        <= n_key;
        r_found      <= n_found;
        r_pos        <= n_pos;
        r_cmp_idx    <= n_cmp_idx;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_cnt    <= n_res_cnt;
        r_res_rm     <= n_res_rm;
        r_status     <= n_status;
        r_count      <= n_count;
        r_removed    <= n_removed;
    end

endmodule

/* src/bckt_ram.sv */
// Generic simple dual-port RAM with registered read.
module bckt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bckt_chk.sv */
// Port-level checker for the bounded counted key table, bound to the top level.
module bckt_chk import bckt_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [CAP_BITS-1:0]        i_cfg_capacity,
    input logic                       i_req_valid,
    input logic                       o_req_ready,
    input logic [1:0]                 i_req_type,
    input logic [KEY_PORT_BITS-1:0]   i_item_key,
    input logic                       o_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [1:0]                 o_status,
    input logic [COUNT_PORT_BITS-1:0] o_count_after,
    input logic                       o_entry_removed
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=>
            o_rsp_valid && $stable(o_status) && $stable(o_count_after)
            && $stable(o_entry_removed))
        else $error("response changed while stalled");

    // one request in flight: no acceptance right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while previous one in progress");

    // a removal leaves nothing behind and always succeeds
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_entry_removed |-> o_status == ST_OK && o_count_after == '0)
        else $error("removal with nonzero count or failing status");

    // refused requests report a zero count and no removal
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_status == ST_NOT_FOUND || o_status == ST_NO_ROOM)
            |-> o_count_after == '0 && !o_entry_removed)
        else $error("refused request reports a count or a removal");

endmodule

bind bounded_counted_key_table bckt_chk u_bckt_chk (.*);

/* sim/bounded_counted_key_table_chk.sv */
`timescale 1ns / 1ps
// Reply scoreboard for the bounded counted key table: mirrors the table and checks every reply.
module bounded_counted_key_table_chk import bckt_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CAP_BITS-1:0]        i_cfg_capacity,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [KEY_PORT_BITS-1:0]   i_item_key,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_ready,
    input  logic [1:0]                 i_status,
    input  logic [COUNT_PORT_BITS-1:0] i_count_after,
    input  logic                       i_entry_removed,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam logic [COUNT_PORT_BITS-1:0] COUNT_TOP = {COUNT_BITS_DEF{1'b1}};
    localparam logic [COUNT_PORT_BITS-1:0] COUNT_ONE = COUNT_PORT_BITS'(1);

    typedef struct packed {
        t_status                    status;
        logic [COUNT_PORT_BITS-1:0] count;
        logic                       removed;
    } table_reply_t;

    // mirror of the table: live entries form a prefix of length occupied
    logic [KEY_PORT_BITS-1:0]   slot_key   [ENTRIES_DEF];
    logic [COUNT_PORT_BITS-1:0] slot_count [ENTRIES_DEF];
    int                         occupied = 0;
    logic [CAP_BITS-1:0]        capacity = CAP_RESET;

    table_reply_t               owed_replies [$];
    table_reply_t               want;
    int                         owed_count = 0;
    int                         mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = owed_count;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: reply mismatch: %s", $time, what);
    endtask

    // close the gap left by a removed entry
    function automatic void drop_slot(input int pos);
        int i;
        for (i = pos; i < occupied - 1; i++) begin
            slot_key[i]   = slot_key[i + 1];
            slot_count[i] = slot_count[i + 1];
        end
        occupied--;
    endfunction

    function automatic table_reply_t table_apply(input t_req kind,
                                                 input logic [KEY_PORT_BITS-1:0] key);
        table_reply_t r;
        int pos;
        int limit;
        int i;
        r.status  = ST_OK;
        r.count   = '0;
        r.removed = 1'b0;
        pos = -1;
        for (i = 0; i < occupied; i++) begin
            if (pos < 0 && slot_key[i] == key) pos = i;
        end
        limit = (int'(capacity) > ENTRIES_DEF) ? ENTRIES_DEF : int'(capacity);
        case (kind)
            REQ_ADD: begin
                if (pos >= 0) begin
                    if (slot_count[pos] == COUNT_TOP) r.status = ST_SATURATED;
                    else slot_count[pos] = slot_count[pos] + 1'b1;
                    r.count = slot_count[pos];
                end else if (occupied < limit) begin
                    slot_key[occupied]   = key;
                    slot_count[occupied] = COUNT_ONE;
                    occupied++;
                    r.count = COUNT_ONE;
                end else begin
                    r.status = ST_NO_ROOM;
                end
            end
            REQ_DEL: begin
                if (pos >= 0) begin
                    drop_slot(pos);
                    r.removed = 1'b1;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            REQ_USE: begin
                if (pos < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (slot_count[pos] <= COUNT_ONE) begin
                    drop_slot(pos);
                    r.removed = 1'b1;
                end else begin
                    slot_count[pos] = slot_count[pos] - 1'b1;
                    r.count = slot_count[pos];
                end
            end
            default: begin
                if (pos >= 0) r.count = slot_count[pos];
                else r.status = ST_NOT_FOUND;
            end
        endcase
        return r;
    endfunction

    // replies are checked before the same edge's request is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            occupied = 0;
            capacity = CAP_RESET;
            owed_replies.delete();
            owed_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) capacity = i_cfg_capacity;
            if (i_rsp_valid && i_rsp_ready) begin
                if (owed_replies.size() == 0) begin
                    report_mismatch("reply with no request outstanding");
                end else begin
                    want = owed_replies.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  i_status, want.status.name()));
                    if (i_count_after !== want.count)
                        report_mismatch($sformatf("count_after %0d, expected %0d",
                                                  i_count_after, want.count));
                    if (i_entry_removed !== want.removed)
                        report_mismatch($sformatf("entry_removed %0b, expected %0b",
                                                  i_entry_removed, want.removed));
                end
            end
            if (i_req_valid && i_req_ready) begin
                owed_replies.insert(owed_replies.size(),
                                    table_apply(t_req'(i_req_type), i_item_key));
            end
            owed_count = owed_replies.size();
        end
    end

endmodule

/* sim/bounded_counted_key_table_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the bounded counted key table: stimulus, watchdog and verdict.
module bounded_counted_key_table_tb;
    import bckt_pkg::*;

    // Watchdog: cycles in a row with no handshake on any channel. The slowest
    // request is a removal at the head of a full table, and random gaps/stalls
    // that reach the limit are vanishingly rare.
    localparam int STALL_LIMIT = 1000;
    // quiet time after the last reply, covers one worst-case request
    localparam int TAIL_CYCLES = 64;
    // random requests per segment; two segments per idling phase
    localparam int SEG_ITEMS   = 192;

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       cfg_valid      = 1'b0;
    logic                       cfg_ready;
    logic [CAP_BITS-1:0]        cfg_capacity   = '0;
    logic                       req_valid      = 1'b0;
    logic                       req_ready;
    logic [1:0]                 req_type       = REQ_LOOKUP;
    logic [KEY_PORT_BITS-1:0]   item_key       = '0;
    logic                       rsp_valid;
    logic                       rsp_ready      = 1'b0;
    logic [1:0]                 status;
    logic [COUNT_PORT_BITS-1:0] count_after;
    logic                       entry_removed;

    int fail_count;
    int pending;
    int stall_cycles   = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    // capacity for each random segment; extremes (0 and above ENTRIES) included
    logic [CAP_BITS-1:0] cap_plan [6] = '{5'd31, 5'd3, 5'd16, 5'd0, 5'd9, 5'd1};

    logic [KEY_PORT_BITS-1:0] key_pool [20];
    int                       pool_size;

    always #1 clk = ~clk;

    bounded_counted_key_table dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_capacity  (cfg_capacity),
        .i_req_valid     (req_valid),
        .o_req_ready     (req_ready),
        .i_req_type      (req_type),
        .i_item_key      (item_key),
        .o_rsp_valid     (rsp_valid),
        .i_rsp_ready     (rsp_ready),
        .o_status        (status),
        .o_count_after   (count_after),
        .o_entry_removed (entry_removed)
    );

    bounded_counted_key_table_chk chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_capacity  (cfg_capacity),
        .i_req_valid     (req_valid),
        .i_req_ready     (req_ready),
        .i_req_type      (req_type),
        .i_item_key      (item_key),
        .i_rsp_valid     (rsp_valid),
        .i_rsp_ready     (rsp_ready),
        .i_status        (status),
        .i_count_after   (count_after),
        .i_entry_removed (entry_removed),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Reply side: ready is redrawn every falling edge from the current stall rate.
    always @(negedge clk) begin
        rsp_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any accepted request, reply or capacity write restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Entered and left at a falling edge. Valid stays up across back-to-back
    // requests; it only drops when the sender decides to idle.
    task automatic send_request(input t_req kind, input logic [KEY_PORT_BITS-1:0] key);
        while ($urandom_range(99) < send_gap_pct) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_type  = kind;
        item_key  = key;
        req_valid = 1'b1;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    // Hold off new requests until every outstanding reply has been taken.
    task automatic drain_replies();
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Capacity only changes while the table is idle.
    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        drain_replies();
        cfg_capacity = cap;
        cfg_valid    = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random traffic over a small key pool so the table fills, hits the limit
    // and shifts; one in ten keys is fully random and mostly misses. Halfway
    // through, the sender drains and the capacity is redrawn.
    task automatic random_segment(input logic [CAP_BITS-1:0] cap);
        int k;
        int pick;
        t_req kind;
        logic [KEY_PORT_BITS-1:0] key;
        write_capacity(cap);
        pool_size = $urandom_range(20, 2);
        for (k = 0; k < pool_size; k++) key_pool[k] = KEY_PORT_BITS'($urandom);
        for (k = 0; k < SEG_ITEMS; k++) begin
            if (k == SEG_ITEMS / 2) write_capacity(CAP_BITS'($urandom_range(31, 0)));
            pick = $urandom_range(99);
            if (pick < 45) kind = REQ_ADD;
            else if (pick < 65) kind = REQ_USE;
            else if (pick < 80) kind = REQ_DEL;
            else kind = REQ_LOOKUP;
            if ($urandom_range(9) == 0) key = KEY_PORT_BITS'($urandom);
            else key = key_pool[$urandom_range(pool_size - 1)];
            send_request(kind, key);
        end
    endtask

    initial begin
        int ph;
        int sg;

        send_gap_pct   = 29;
        recv_stall_pct = 68;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // --- directed: empty table, reset capacity ---
        send_request(REQ_LOOKUP, 16'h0000);   // miss on empty table
        send_request(REQ_DEL,    16'hFFFF);   // delete of absent key
        send_request(REQ_USE,    16'h1234);   // use of absent key
        send_request(REQ_ADD,    16'h0000);
        send_request(REQ_ADD,    16'hFFFF);
        send_request(REQ_ADD,    16'hFFFF);   // increment existing
        send_request(REQ_LOOKUP, 16'hFFFF);
        send_request(REQ_USE,    16'hFFFF);   // decrement, stays
        send_request(REQ_USE,    16'h0000);   // count hits zero: removed, tail shifts
        send_request(REQ_LOOKUP, 16'hFFFF);

        // capacity 2: fill, then refuse a new key
        write_capacity(5'd2);
        send_request(REQ_ADD,    16'h00AA);
        send_request(REQ_ADD,    16'h5555);   // no room

        // capacity below occupancy: existing keys still count up, new ones refused
        write_capacity(5'd0);
        send_request(REQ_ADD,    16'h00AA);
        send_request(REQ_ADD,    16'h5555);
        send_request(REQ_DEL,    16'hFFFF);   // head delete
        send_request(REQ_ADD,    16'h5555);   // still refused at capacity 0

        // capacity above ENTRIES behaves as ENTRIES
        write_capacity(5'd31);
        send_request(REQ_ADD,    16'h5555);
        send_request(REQ_ADD,    16'h0F0F);
        send_request(REQ_DEL,    16'h5555);   // middle delete closes the gap
        send_request(REQ_LOOKUP, 16'h0F0F);
        send_request(REQ_USE,    16'h00AA);
        send_request(REQ_USE,    16'h00AA);
        send_request(REQ_DEL,    16'h0F0F);   // table empty again

        // --- random: sender-light, then receiver-light, then no idling ---
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct   = 29;
                    recv_stall_pct = 68;
                end
                1: begin
                    send_gap_pct   = 68;
                    recv_stall_pct = 29;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (sg = 0; sg < 2; sg++) random_segment(cap_plan[ph * 2 + sg]);
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
